FILE: rtl/nbody_gravity_step_2d_macros.svh
`ifndef NBODY_GRAVITY_STEP_2D_MACROS_SVH
`define NBODY_GRAVITY_STEP_2D_MACROS_SVH

// Implication in the same cycle.
`define NBG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the following cycle.
`define NBG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/nbg_pkg.sv
package nbg_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W = 52;
  localparam int DIST_W = 26;
  localparam int AXIS_W = 25;
  localparam int NUM_W = 57;
  localparam int MAG_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;

  localparam logic [6:0] PARTICLE_COUNT_RST = 7'd64;
  localparam logic [15:0] MIN_DISTANCE_RST = 16'd20;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [5:0] slot;
    logic [15:0] mass_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
  } req_t;

  typedef struct packed {
    logic [5:0] slot_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic saturated;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic sat;
    logic [15:0] mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } prt_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_I, ST_RD_J, ST_CAP_J, ST_ABS, ST_SQX, ST_SQY, ST_SUM,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_DSQ, ST_DD, ST_MUL, ST_T_GO, ST_T_WAIT,
    ST_M_GO, ST_M_WAIT, ST_APPLY, ST_WB_I, ST_WB_J, ST_FIN_RD, ST_FIN_CAP,
    ST_FIN_ADD, ST_FIN_OUT
  } st_t;

  // Returns the overflow flag above the saturated 32-bit sum.
  function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [41:0] b);
    logic signed [42:0] s;
    s = 43'(a) + 43'(b);
    if (s > 43'sd2147483647) return {1'b1, 32'h7fffffff};
    else if (s < -43'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, s[31:0]};
  endfunction

endpackage

FILE: rtl/nbg_ram.sv
module nbg_ram import nbg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nbg_sqrt.sv
module nbg_sqrt import nbg_pkg::*; #(
  parameter int IN_W = SQ_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   value,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  logic [IN_W-1:0] x;
  logic [IN_W-1:0] r;
  logic [IN_W-1:0] b;
  logic            busy;
  logic [IN_W-1:0] trial;

  assign trial = r + b;
  assign root = r[IN_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x <= value;
        r <= '0;
        b <= {2'b01, {(IN_W-2){1'b0}}};
      end else if (busy) begin
        if (x >= trial) begin
          x <= x - trial;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b == IN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/nbg_div.sv
module nbg_div import nbg_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = SQ_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D_W:0]     sh;

  assign sh = {rem, quo[N_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= num;
        dvs <= den;
        cnt <= '0;
      end else if (busy) begin
        if (sh >= {1'b0, dvs}) begin
          rem <= D_W'(sh - {1'b0, dvs});
          quo <= {quo[N_W-2:0], 1'b1};
        end else begin
          rem <= sh[D_W-1:0];
          quo <= {quo[N_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/nbody_gravity_step_2d.sv
// A load is written as it is accepted. A step visits every pair once, one pair at
// a time; only a pair above the threshold uses the shared bit-serial divider, for
// eight divisions. Each particle is then read, moved by its velocity, written back
// and offered as a result, held there while the result transfer is stalled.
// Reset (synchronous, active high) restores the registers and idles the sequencer;
// the particle memory keeps its contents and needs no clearing pass.
module nbody_gravity_step_2d import nbg_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int REC_W = $bits(prt_t);

  st_t state, state_next;

  logic [6:0]        particle_count;
  logic [15:0]       min_distance;
  logic [ADDR_W-1:0] i, j, p, n_m1;
  logic              one_only;
  logic [1:0]        k;
  prt_t              rec_i, rec_j, rec_wr, rec_rd, fin_rec;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  logic [AXIS_W-1:0] ax, ay;
  logic              neg_x, neg_y;
  logic [SQ_W-1:0]   prod, acc, dd;
  logic [SQ_W-1:0]   mul_p;
  logic [DIST_W-1:0] mul_a, mul_b, d, root;
  logic              sqrt_start, sqrt_done;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [SQ_W-1:0]   div_den;
  logic [31:0]       t;
  logic [MAG_W-1:0]  mag;
  logic [CNT_W-1:0]  n_start;
  logic              load_ok;
  logic [32:0]       dx, dy, adx, ady;
  logic signed [41:0] delta;
  logic [32:0]       sum_v, sum_px, sum_py;

  assign cfg_ready = 1'b1;
  assign rec_rd = prt_t'(ram_rdata);
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= PARTICLE_COUNT_RST;
      min_distance <= MIN_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PARTICLE_COUNT: particle_count <= cfg_data[6:0];
        REG_MIN_DISTANCE: min_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(particle_count) > MAX_PARTICLES) n_start = CNT_W'(MAX_PARTICLES);
    else n_start = CNT_W'(particle_count);
    load_ok = int'(req.slot) < MAX_PARTICLES;
  end

  nbg_ram #(.WIDTH(REC_W), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rec_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nbg_sqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (acc),
    .done  (sqrt_done),
    .root  (root)
  );

  nbg_div #(.N_W(NUM_W), .D_W(SQ_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    dx = {rec_i.pos_x[31], rec_i.pos_x} - {rec_j.pos_x[31], rec_j.pos_x};
    dy = {rec_i.pos_y[31], rec_i.pos_y} - {rec_j.pos_y[31], rec_j.pos_y};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
    delta = (k[0] ? neg_y : neg_x) ? -42'(mag) : 42'(mag);
    if (k[1]) begin
      sum_v = sat_add(k[0] ? rec_j.vel_y : rec_j.vel_x, delta);
    end else begin
      sum_v = sat_add(k[0] ? rec_i.vel_y : rec_i.vel_x, -delta);
    end
    sum_px = sat_add(rec_i.pos_x, 42'(rec_i.vel_x));
    sum_py = sat_add(rec_i.pos_y, 42'(rec_i.vel_y));
    fin_rec = rec_i;
    fin_rec.pos_x = sum_px[31:0];
    fin_rec.pos_y = sum_py[31:0];
    fin_rec.sat = rec_i.sat | sum_px[32] | sum_py[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    ram_we = 1'b0;
    ram_waddr = i;
    ram_raddr = i;
    rec_wr = rec_i;
    sqrt_start = 1'b0;
    div_start = 1'b0;
    div_num = {prod[40:0], 16'd0};
    div_den = SQ_W'(d);
    mul_a = DIST_W'(ax);
    mul_b = DIST_W'(ax);
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        ram_waddr = ADDR_W'(req.slot);
        rec_wr = '{sat: 1'b0, mass: req.mass_in, pos_x: req.pos_x_in,
                   pos_y: req.pos_y_in, vel_x: req.vel_x_in, vel_y: req.vel_y_in};
        if (req_valid) begin
          if (req.req_type == REQ_LOAD) begin
            ram_we = load_ok;
          end else if (n_start == CNT_W'(1)) begin
            state_next = ST_FIN_RD;
          end else if (n_start != '0) begin
            state_next = ST_RD_I;
          end
        end
      end
      ST_RD_I: state_next = ST_RD_J;
      ST_RD_J: begin
        ram_raddr = j;
        state_next = ST_CAP_J;
      end
      ST_CAP_J: state_next = ST_ABS;
      ST_ABS: state_next = ST_SQX;
      ST_SQX: state_next = ST_SQY;
      ST_SQY: begin
        mul_a = DIST_W'(ay);
        mul_b = DIST_W'(ay);
        state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_SQRT_GO;
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (sqrt_done) state_next = ST_DSQ;
      ST_DSQ: begin
        mul_a = d;
        mul_b = d;
        state_next = (d > {2'b00, min_distance, 8'd0}) ? ST_DD : ST_WB_I;
      end
      ST_DD: state_next = ST_MUL;
      ST_MUL: begin
        mul_a = DIST_W'(k[1] ? rec_i.mass : rec_j.mass);
        mul_b = DIST_W'(k[0] ? ay : ax);
        state_next = ST_T_GO;
      end
      ST_T_GO: begin
        div_start = 1'b1;
        state_next = ST_T_WAIT;
      end
      ST_T_WAIT: if (div_done) state_next = ST_M_GO;
      ST_M_GO: begin
        div_start = 1'b1;
        div_num = NUM_W'({t, 8'd0});
        div_den = dd;
        state_next = ST_M_WAIT;
      end
      ST_M_WAIT: if (div_done) state_next = ST_APPLY;
      ST_APPLY: state_next = (k == 2'd3) ? ST_WB_I : ST_MUL;
      ST_WB_I: begin
        ram_we = 1'b1;
        state_next = ST_WB_J;
      end
      ST_WB_J: begin
        ram_we = 1'b1;
        ram_waddr = j;
        rec_wr = rec_j;
        if (j == n_m1 && i + 1'b1 == n_m1) state_next = ST_FIN_RD;
        else state_next = ST_RD_I;
      end
      ST_FIN_RD: begin
        ram_raddr = p;
        state_next = ST_FIN_CAP;
      end
      ST_FIN_CAP: state_next = ST_FIN_ADD;
      ST_FIN_ADD: begin
        ram_we = 1'b1;
        ram_waddr = p;
        rec_wr = fin_rec;
        state_next = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) state_next = (p == n_m1) ? ST_IDLE : ST_FIN_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    unique case (state)
      ST_IDLE: begin
        i <= '0;
        j <= ADDR_W'(1);
        p <= '0;
        n_m1 <= ADDR_W'(n_start - 1'b1);
        one_only <= (n_start == CNT_W'(1));
      end
      ST_RD_J: begin
        rec_i <= prt_t'({rec_rd.sat && !(i == '0 && j == ADDR_W'(1)),
                         rec_rd[REC_W-2:0]});
      end
      ST_CAP_J: begin
        rec_j <= prt_t'({rec_rd.sat && (i != '0), rec_rd[REC_W-2:0]});
      end
      ST_ABS: begin
        ax <= adx[32:8];
        ay <= ady[32:8];
        neg_x <= dx[32];
        neg_y <= dy[32];
        k <= '0;
      end
      ST_SQY: acc <= prod;
      ST_SUM: acc <= acc + prod;
      ST_SQRT_WAIT: if (sqrt_done) d <= root;
      ST_DD: dd <= prod;
      ST_T_WAIT: if (div_done) t <= div_quo[31:0];
      ST_M_WAIT: if (div_done) mag <= div_quo[MAG_W-1:0];
      ST_APPLY: begin
        k <= k + 1'b1;
        unique case (k)
          2'd0: begin
            rec_i.vel_x <= sum_v[31:0];
            rec_i.sat <= rec_i.sat | sum_v[32];
          end
          2'd1: begin
            rec_i.vel_y <= sum_v[31:0];
            rec_i.sat <= rec_i.sat | sum_v[32];
          end
          2'd2: begin
            rec_j.vel_x <= sum_v[31:0];
            rec_j.sat <= rec_j.sat | sum_v[32];
          end
          default: begin
            rec_j.vel_y <= sum_v[31:0];
            rec_j.sat <= rec_j.sat | sum_v[32];
          end
        endcase
      end
      ST_WB_J: begin
        if (j == n_m1) begin
          i <= i + 1'b1;
          j <= i + ADDR_W'(2);
        end else begin
          j <= j + 1'b1;
        end
      end
      ST_FIN_CAP: begin
        rec_i <= prt_t'({rec_rd.sat && !one_only, rec_rd[REC_W-2:0]});
      end
      ST_FIN_ADD: begin
        rsp.slot_out <= 6'(p);
        rsp.pos_x_out <= fin_rec.pos_x;
        rsp.pos_y_out <= fin_rec.pos_y;
        rsp.vel_x_out <= fin_rec.vel_x;
        rsp.vel_y_out <= fin_rec.vel_y;
        rsp.saturated <= fin_rec.sat;
        rsp.last <= (p == n_m1);
      end
      ST_FIN_OUT: if (!rsp_stall) p <= p + 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/nbg_checker.sv
`include "nbody_gravity_step_2d_macros.svh"

module nbg_checker import nbg_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `NBG_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `NBG_ASSERT_IMP(a_busy_when_reporting, clk, rst, rsp_valid, req_stall)
  `NBG_ASSERT_NXT(a_run_continues, clk, rst, rsp_valid && !rsp_stall && !rsp.last, req_stall)
  `NBG_ASSERT_NXT(a_load_silent, clk, rst,
                  req_valid && !req_stall && req.req_type == REQ_LOAD, !rsp_valid)

endmodule

bind nbody_gravity_step_2d nbg_checker u_nbg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nbg_pkg::*;

  localparam int TABLE_DEPTH = MAX_PARTICLES_DEF;
  localparam longint unsigned CYCLE_LIMIT = 20000000;

  class gravity_scoreboard;
    logic [15:0] mass[TABLE_DEPTH];
    logic signed [31:0] px[TABLE_DEPTH];
    logic signed [31:0] py[TABLE_DEPTH];
    logic signed [31:0] vx[TABLE_DEPTH];
    logic signed [31:0] vy[TABLE_DEPTH];
    bit sat[TABLE_DEPTH];
    longint unsigned count_reg;
    longint unsigned min_dist_reg;
    rsp_t pending[$];
    string why;

    function new();
      count_reg = PARTICLE_COUNT_RST;
      min_dist_reg = MIN_DISTANCE_RST;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        mass[k] = '0;
        px[k] = '0;
        py[k] = '0;
        vx[k] = '0;
        vy[k] = '0;
        sat[k] = 0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PARTICLE_COUNT) count_reg = val & 16'h7f;
      else if (idx == REG_MIN_DISTANCE) min_dist_reg = val;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [31:0] clamp_add(int k, logic signed [31:0] a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > 64'sd2147483647) begin
        sat[k] = 1;
        return 32'h7fffffff;
      end
      if (s < -64'sd2147483648) begin
        sat[k] = 1;
        return 32'h80000000;
      end
      return s[31:0];
    endfunction

    function longint pull(longint unsigned m, longint unsigned a, longint unsigned d, bit neg);
      longint unsigned t;
      longint unsigned mg;
      t = ((m * a) << 16) / d;
      mg = (t << 8) / (d * d);
      return neg ? -longint'(mg) : longint'(mg);
    endfunction

    function void pair_force(int i, int j);
      longint dx;
      longint dy;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned d;
      longint fxi;
      longint fyi;
      longint fxj;
      longint fyj;
      dx = longint'(px[i]) - longint'(px[j]);
      dy = longint'(py[i]) - longint'(py[j]);
      ax = (dx < 0 ? -dx : dx) >> 8;
      ay = (dy < 0 ? -dy : dy) >> 8;
      d = root_floor(ax * ax + ay * ay);
      if (d <= (min_dist_reg << 8)) return;
      fxi = pull(mass[j], ax, d, dx < 0);
      fyi = pull(mass[j], ay, d, dy < 0);
      fxj = pull(mass[i], ax, d, dx < 0);
      fyj = pull(mass[i], ay, d, dy < 0);
      vx[i] = clamp_add(i, vx[i], -fxi);
      vy[i] = clamp_add(i, vy[i], -fyi);
      vx[j] = clamp_add(j, vx[j], fxj);
      vy[j] = clamp_add(j, vy[j], fyj);
    endfunction

    function void note_request(req_t r);
      int n;
      rsp_t e;
      if (r.req_type == REQ_LOAD) begin
        mass[r.slot] = r.mass_in;
        px[r.slot] = r.pos_x_in;
        py[r.slot] = r.pos_y_in;
        vx[r.slot] = r.vel_x_in;
        vy[r.slot] = r.vel_y_in;
        return;
      end
      n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
      for (int k = 0; k < TABLE_DEPTH; k++) sat[k] = 0;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) pair_force(i, j);
      for (int i = 0; i < n; i++) begin
        px[i] = clamp_add(i, px[i], longint'(vx[i]));
        py[i] = clamp_add(i, py[i], longint'(vy[i]));
        e.slot_out = i[5:0];
        e.pos_x_out = px[i];
        e.pos_y_out = py[i];
        e.vel_x_out = vx[i];
        e.vel_y_out = vy[i];
        e.saturated = sat[i];
        e.last = (i + 1 == n);
        pending.push_back(e);
      end
    endfunction

    function bit check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        why = $sformatf("unexpected result for slot %0d", got.slot_out);
        return 0;
      end
      e = pending.pop_front();
      if (got !== e) begin
        why = $sformatf({"slot %0d/%0d px %h/%h py %h/%h vx %h/%h vy %h/%h",
                         " sat %b/%b last %b/%b (got/exp)"},
                        got.slot_out, e.slot_out, got.pos_x_out, e.pos_x_out,
                        got.pos_y_out, e.pos_y_out, got.vel_x_out, e.vel_x_out,
                        got.vel_y_out, e.vel_y_out, got.saturated, e.saturated,
                        got.last, e.last);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gravity_scoreboard book = new();
  int errors = 0;
  int sent_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint unsigned cycles = 0;

  nbody_gravity_step_2d dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        if (!book.check_response(rsp)) report(book.why);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    book.note_request(r);
    sent_items++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.write_register(idx, val);
  endtask

  task automatic load_particle(logic [5:0] s, logic [15:0] m, logic [31:0] x,
                               logic [31:0] y, logic [31:0] u, logic [31:0] w);
    req_t r;
    r.req_type = REQ_LOAD;
    r.slot = s;
    r.mass_in = m;
    r.pos_x_in = x;
    r.pos_y_in = y;
    r.vel_x_in = u;
    r.vel_y_in = w;
    send_request(r);
  endtask

  task automatic run_step();
    req_t r;
    r = '0;
    r.req_type = REQ_STEP;
    r.slot = 6'($urandom);
    r.mass_in = 16'($urandom);
    r.pos_x_in = $urandom;
    r.pos_y_in = $urandom;
    r.vel_x_in = $urandom;
    r.vel_y_in = $urandom;
    send_request(r);
  endtask

  function automatic logic [31:0] scaled_word(int shift);
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom) >>> shift);
    endcase
  endfunction

  task automatic load_random(logic [5:0] s, int pos_shift);
    load_particle(s, 16'($urandom), scaled_word(pos_shift), scaled_word(pos_shift),
                  scaled_word(15), scaled_word(15));
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 73;
    write_register(REG_PARTICLE_COUNT, 16'd2);
    write_register(REG_MIN_DISTANCE, 16'd0);
    load_particle(6'd0, 16'h0000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    load_particle(6'd1, 16'hffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    run_step();
    load_particle(6'd0, 16'h0100, 32'h00010000, 32'hfff00000, 32'h0, 32'h0);
    load_particle(6'd1, 16'h8000, 32'h00010000, 32'hfff00000, 32'h0, 32'h0);
    run_step();
    load_particle(6'd1, 16'hffff, 32'h00350000, 32'hffd00000, 32'h00001000, 32'hffff0000);
    run_step();
    drain();
    write_register(REG_PARTICLE_COUNT, 16'd0);
    run_step();
    drain();
    write_register(REG_PARTICLE_COUNT, 16'd3);
    write_register(REG_MIN_DISTANCE, 16'hffff);
    for (int k = 0; k < 3; k++) load_random(6'(k), 0);
    run_step();
    drain();

    // All slots are loaded before any step that reads them.
    write_register(REG_PARTICLE_COUNT, 16'h007f);
    for (int k = 0; k < TABLE_DEPTH; k++) load_random(6'(k), 3);
    run_step();
    drain();

    while (sent_items < 105) begin
      if (sent_items < 88) begin
        send_idle_pct = 29;
        recv_idle_pct = 73;
      end else if (sent_items < 97) begin
        send_idle_pct = 73;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = $urandom_range(1, 8);
      write_register(REG_PARTICLE_COUNT, 16'(n));
      if ($urandom_range(4) == 0) write_register(REG_MIN_DISTANCE, 16'($urandom));
      else write_register(REG_MIN_DISTANCE, 16'($urandom_range(0, 300)));
      repeat ($urandom_range(0, n)) begin
        if ($urandom_range(5) == 0) load_random(6'($urandom), 7);
        else load_random(6'($urandom_range(0, n - 1)), 7);
      end
      repeat ($urandom_range(1, 2)) run_step();
      drain();
    end

    req_valid <= 1'b0;
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/nbg_pkg.sv
rtl/nbg_ram.sv
rtl/nbg_sqrt.sv
rtl/nbg_div.sv
rtl/nbody_gravity_step_2d.sv
rtl/nbg_checker.sv
sim/testbench.sv
